[rtl/core/ppc64_integer_alu_assert.svh]
// Assertion macros for the integer ALU.
// Included by the top level; no other dependencies.
`ifndef PPC64_INTEGER_ALU_ASSERT_SVH
`define PPC64_INTEGER_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define ALU_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ALU_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ALU_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define ALU_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

[rtl/core/ppc_alu_pkg.sv]
// Package for the integer ALU: opcodes, payload structs, controller types.
// No dependencies.
package ppc_alu_pkg;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDC = 6'd1, OP_ADDE = 6'd2, OP_ADDI = 6'd3, OP_ADDIC = 6'd4,
        OP_ADDIS = 6'd5, OP_ADDME = 6'd6, OP_ADDZE = 6'd7, OP_AND = 6'd8, OP_ANDC = 6'd9,
        OP_ANDI = 6'd10, OP_ANDIS = 6'd11, OP_CMP = 6'd12, OP_CMPI = 6'd13,
        OP_CMPL = 6'd14, OP_CMPLI = 6'd15, OP_CNTLZD = 6'd16, OP_CNTLZW = 6'd17,
        OP_DIVD = 6'd18, OP_DIVDU = 6'd19, OP_DIVW = 6'd20, OP_DIVWU = 6'd21,
        OP_EQV = 6'd22, OP_EXTSB = 6'd23, OP_EXTSH = 6'd24, OP_EXTSW = 6'd25,
        OP_MULHD = 6'd26, OP_MULHDU = 6'd27, OP_MULHW = 6'd28, OP_MULHWU = 6'd29,
        OP_MULLD = 6'd30, OP_MULLI = 6'd31, OP_MULLW = 6'd32, OP_NAND = 6'd33,
        OP_NEG = 6'd34, OP_NOR = 6'd35, OP_OR = 6'd36, OP_ORC = 6'd37, OP_ORI = 6'd38,
        OP_ORIS = 6'd39, OP_RLDIC = 6'd40, OP_RLDICL = 6'd41, OP_RLDICR = 6'd42,
        OP_RLDIMI = 6'd43, OP_RLWIMI = 6'd44, OP_RLWINM = 6'd45, OP_RLWNM = 6'd46,
        OP_SLW = 6'd47, OP_SRAW = 6'd48, OP_SRAWI = 6'd49, OP_SRW = 6'd50,
        OP_SUBF = 6'd51, OP_SUBFC = 6'd52, OP_SUBFE = 6'd53, OP_SUBFIC = 6'd54,
        OP_SUBFME = 6'd55, OP_SUBFZE = 6'd56, OP_XOR = 6'd57, OP_XORI = 6'd58,
        OP_XORIS = 6'd59
    } op_t;

    localparam logic [4:0] LOW5 = 5'h1F;
    localparam logic [5:0] LOW6 = 6'h3F;

    typedef struct packed {
        logic [5:0]  func;
        logic [63:0] src_a;
        logic [63:0] src_b;
        logic [15:0] imm;
        logic        base_is_zero;
        logic [5:0]  shift;
        logic [5:0]  mask_begin;
        logic [5:0]  mask_end;
        logic        record;
        logic        doubleword_compare;
        logic [2:0]  cr_target;
    } alu_in_t;

    typedef struct packed {
        logic [63:0] result;
        logic        result_valid;
        logic        carry_out;
        logic        carry_updated;
        logic [2:0]  cr_index;
        logic [3:0]  cr_value;
        logic        cr_updated;
    } alu_out_t;

    // op classes steering the controller
    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
    } op_class_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_DIV_SETUP, ST_DIV, ST_DIV_FIX, ST_FINISH, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_step1;
        logic mul_step2;
        logic div_setup;
        logic div_step;
        logic div_fix;
        logic finish;
        logic out_take;
    } ctl_cmd_t;

    typedef struct packed {
        op_class_t cls;
        logic      div_last;
    } ctl_sts_t;

    // Big-endian mask from MB to ME, wrapping when MB > ME.
    function automatic logic [63:0] mask_be(input logic [5:0] b, input logic [5:0] e);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = {64{1'b1}} >> b;
        hi = {64{1'b1}} << (6'd63 - e);
        return (b <= e) ? (lo & hi) : (lo | hi);
    endfunction

    function automatic logic [3:0] cmp_code(input logic [63:0] x, input logic [63:0] y,
                                            input logic sgn);
        logic [63:0] xs;
        logic [63:0] ys;
        xs = x ^ {sgn, 63'd0};
        ys = y ^ {sgn, 63'd0};
        return (xs < ys) ? 4'b1000 : ((xs > ys) ? 4'b0100 : 4'b0010);
    endfunction

endpackage

[rtl/core/ppc_alu_ctrl.sv]
// Controller state machine for the integer ALU.
// Depends on ppc_alu_pkg.
module ppc_alu_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  ppc_alu_pkg::ctl_sts_t   sts,
    output ppc_alu_pkg::ctl_cmd_t   cmd
);

    ppc_alu_pkg::state_t state_reg;
    ppc_alu_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppc_alu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppc_alu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (sts.cls)
                        ppc_alu_pkg::CLS_MUL: state_next = ppc_alu_pkg::ST_MUL1;
                        ppc_alu_pkg::CLS_DIV: state_next = ppc_alu_pkg::ST_DIV_SETUP;
                        default:              state_next = ppc_alu_pkg::ST_FINISH;
                    endcase
                end
            end
            ppc_alu_pkg::ST_MUL1:      state_next = ppc_alu_pkg::ST_MUL2;
            ppc_alu_pkg::ST_MUL2:      state_next = ppc_alu_pkg::ST_FINISH;
            ppc_alu_pkg::ST_DIV_SETUP: state_next = ppc_alu_pkg::ST_DIV;
            ppc_alu_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ppc_alu_pkg::ST_DIV_FIX;
                end
            end
            ppc_alu_pkg::ST_DIV_FIX:   state_next = ppc_alu_pkg::ST_FINISH;
            ppc_alu_pkg::ST_FINISH:    state_next = ppc_alu_pkg::ST_OUT;
            ppc_alu_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ppc_alu_pkg::ST_IDLE;
                end
            end
            default:                   state_next = ppc_alu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ppc_alu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ppc_alu_pkg::ST_MUL1:      cmd.mul_step1 = 1'b1;
            ppc_alu_pkg::ST_MUL2:      cmd.mul_step2 = 1'b1;
            ppc_alu_pkg::ST_DIV_SETUP: cmd.div_setup = 1'b1;
            ppc_alu_pkg::ST_DIV:       cmd.div_step  = 1'b1;
            ppc_alu_pkg::ST_DIV_FIX:   cmd.div_fix   = 1'b1;
            ppc_alu_pkg::ST_FINISH:    cmd.finish    = 1'b1;
            ppc_alu_pkg::ST_OUT:
            begin
                out_valid    = 1'b1;
                cmd.out_take = out_ready;
            end
            default:                   cmd = '0;
        endcase
    end

endmodule

[rtl/core/ppc_alu_dp.sv]
// Datapath for the integer ALU: operand latch, 32x32 multiplier, radix-2
// divider, result selection, carry flag and output register. Uses ppc_alu_pkg.
module ppc_alu_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ppc_alu_pkg::alu_in_t    in_data,
    output ppc_alu_pkg::alu_out_t   out_data,
    input  ppc_alu_pkg::ctl_cmd_t   cmd,
    output ppc_alu_pkg::ctl_sts_t   sts
);

    ppc_alu_pkg::alu_in_t op_reg;
    logic        carry_reg;
    logic        carry_next;
    logic [63:0] pp_reg [4];
    logic [63:0] mullo_reg;
    logic [63:0] mulhi_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        dz_reg;
    logic [63:0] divres_reg;
    ppc_alu_pkg::alu_out_t out_reg;
    ppc_alu_pkg::alu_out_t out_next;

    ppc_alu_pkg::op_t f;
    logic [63:0] a;
    logic [63:0] b;
    assign f = ppc_alu_pkg::op_t'(op_reg.func);
    assign a = op_reg.src_a;
    assign b = op_reg.src_b;

    // classify incoming op for the controller
    always_comb
    begin
        sts.div_last = (cnt_reg == 6'd63);
        case (in_data.func)
            ppc_alu_pkg::OP_MULHD, ppc_alu_pkg::OP_MULHDU, ppc_alu_pkg::OP_MULHW,
            ppc_alu_pkg::OP_MULHWU, ppc_alu_pkg::OP_MULLD, ppc_alu_pkg::OP_MULLI,
            ppc_alu_pkg::OP_MULLW:
                sts.cls = ppc_alu_pkg::CLS_MUL;
            ppc_alu_pkg::OP_DIVD, ppc_alu_pkg::OP_DIVDU, ppc_alu_pkg::OP_DIVW,
            ppc_alu_pkg::OP_DIVWU:
                sts.cls = ppc_alu_pkg::CLS_DIV;
            default:
                sts.cls = ppc_alu_pkg::CLS_SIMPLE;
        endcase
    end

    // multiplier operands: sign/width adjusted 64-bit values, product low 128 bits
    logic [63:0] ma;
    logic [63:0] mbv;
    logic        ma_sgn;
    logic        mb_sgn;
    always_comb
    begin
        ma     = a;
        mbv    = b;
        ma_sgn = 1'b0;
        mb_sgn = 1'b0;
        case (f)
            ppc_alu_pkg::OP_MULHD:
            begin
                ma_sgn = a[63];
                mb_sgn = b[63];
            end
            ppc_alu_pkg::OP_MULHW, ppc_alu_pkg::OP_MULLW:
            begin
                ma = {{32{a[31]}}, a[31:0]};
                mbv = {{32{b[31]}}, b[31:0]};
            end
            ppc_alu_pkg::OP_MULHWU:
            begin
                ma = {32'd0, a[31:0]};
                mbv = {32'd0, b[31:0]};
            end
            ppc_alu_pkg::OP_MULLI: mbv = {{48{op_reg.imm[15]}}, op_reg.imm};
            default: ;
        endcase
    end

    // step 1: four 32x32 partial products
    // step 2: combine into high and low words, signed correction for mulhd
    logic [127:0] prod;
    assign prod = {64'd0, pp_reg[0]} + ({64'd0, pp_reg[1]} << 32)
                + ({64'd0, pp_reg[2]} << 32) + ({pp_reg[3], 64'd0});

    // divider setup: magnitudes
    logic [63:0] da;
    logic [63:0] db;
    logic        dsgn;
    always_comb
    begin
        da   = a;
        db   = b;
        dsgn = 1'b0;
        case (f)
            ppc_alu_pkg::OP_DIVD:  dsgn = 1'b1;
            ppc_alu_pkg::OP_DIVW:
            begin
                da   = {{32{a[31]}}, a[31:0]};
                db   = {{32{b[31]}}, b[31:0]};
                dsgn = 1'b1;
            end
            ppc_alu_pkg::OP_DIVWU:
            begin
                da = {32'd0, a[31:0]};
                db = {32'd0, b[31:0]};
            end
            default: ;
        endcase
    end

    logic [64:0] rsh;
    logic [64:0] rdiff;
    assign rsh   = {rem_reg, quo_reg[63]};
    assign rdiff = rsh - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_data;
        end
        if (cmd.mul_step1)
        begin
            pp_reg[0] <= {32'd0, ma[31:0]} * {32'd0, mbv[31:0]};
            pp_reg[1] <= {32'd0, ma[31:0]} * {32'd0, mbv[63:32]};
            pp_reg[2] <= {32'd0, ma[63:32]} * {32'd0, mbv[31:0]};
            pp_reg[3] <= {32'd0, ma[63:32]} * {32'd0, mbv[63:32]};
        end
        if (cmd.mul_step2)
        begin
            mullo_reg <= prod[63:0];
            mulhi_reg <= prod[127:64] - (ma_sgn ? mbv : 64'd0) - (mb_sgn ? ma : 64'd0);
        end
        if (cmd.div_setup)
        begin
            rem_reg <= 64'd0;
            quo_reg <= (dsgn && da[63]) ? (64'd0 - da) : da;
            dvs_reg <= (dsgn && db[63]) ? (64'd0 - db) : db;
            neg_reg <= dsgn && (da[63] ^ db[63]);
            // zero divisor, or most negative value divided by minus one
            dz_reg  <= (db == 64'd0) || (dsgn && da == {1'b1, 63'd0} && db == '1)
                       || (f == ppc_alu_pkg::OP_DIVW && a[31:0] == 32'h8000_0000
                           && b[31:0] == 32'hFFFF_FFFF);
            cnt_reg <= 6'd0;
        end
        if (cmd.div_step)
        begin
            if (!rdiff[64])
            begin
                rem_reg <= rdiff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rsh[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 6'd1;
        end
        if (cmd.div_fix)
        begin
            divres_reg <= dz_reg ? 64'd0 : (neg_reg ? (64'd0 - quo_reg) : quo_reg);
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            carry_reg <= carry_next;
        end
    end

    // result selection for all ops; mul and div ops take their registered results
    logic [63:0] sx_imm;
    logic [63:0] rot_src;
    logic [5:0]  rot_n;
    logic [63:0] rot;
    logic [63:0] msk;
    logic [64:0] sum;
    logic [63:0] add_x;
    logic [63:0] add_y;
    logic        add_c;
    logic [63:0] clz_v;
    logic [6:0]  clz_n;
    logic [63:0] w;
    logic [5:0]  n;
    logic [63:0] r;
    logic        valid;
    logic        rec;
    logic        cset;
    logic        cmp;
    logic        csgn;
    logic [63:0] cx;
    logic [63:0] cy;
    logic        ca;

    assign sx_imm = {{48{op_reg.imm[15]}}, op_reg.imm};
    assign sum    = {1'b0, add_x} + {1'b0, add_y} + {64'd0, add_c};
    assign rot    = (rot_src << rot_n) | (rot_src >> (7'd64 - {1'b0, rot_n}));

    // priority search over 64 bits as a leading-one encoder
    always_comb
    begin
        clz_n = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            if (clz_v[i])
            begin
                clz_n = 7'(63 - i);
            end
        end
    end

    always_comb
    begin
        add_x   = a;
        add_y   = b;
        add_c   = 1'b0;
        rot_src = a;
        rot_n   = op_reg.shift;
        msk     = '1;
        clz_v   = a;
        w       = {{32{a[31]}}, a[31:0]};
        n       = 6'd0;
        r       = 64'd0;
        valid   = 1'b1;
        rec     = op_reg.record;
        cset    = 1'b0;
        cmp     = 1'b0;
        csgn    = 1'b1;
        cx      = 64'd0;
        cy      = 64'd0;
        ca      = carry_reg;
        case (op_reg.func)
            ppc_alu_pkg::OP_ADD: r = a + b;
            ppc_alu_pkg::OP_ADDC:
            begin
                r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_ADDE:
            begin
                add_c = carry_reg; r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_ADDI:
            begin
                r = (op_reg.base_is_zero ? 64'd0 : a) + sx_imm; rec = 1'b0;
            end
            ppc_alu_pkg::OP_ADDIC:
            begin
                add_y = sx_imm; r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_ADDIS:
            begin
                r = (op_reg.base_is_zero ? 64'd0 : a) + (sx_imm << 16); rec = 1'b0;
            end
            ppc_alu_pkg::OP_ADDME:
            begin
                add_y = '1; add_c = carry_reg; r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_ADDZE:
            begin
                add_y = '0; add_c = carry_reg; r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_AND:   r = a & b;
            ppc_alu_pkg::OP_ANDC:  r = a & ~b;
            ppc_alu_pkg::OP_ANDI:
            begin
                r = a & {48'd0, op_reg.imm}; rec = 1'b1;
            end
            ppc_alu_pkg::OP_ANDIS:
            begin
                r = a & {32'd0, op_reg.imm, 16'd0}; rec = 1'b1;
            end
            ppc_alu_pkg::OP_CMP:
            begin
                cmp = 1'b1;
                cx = op_reg.doubleword_compare ? a : {{32{a[31]}}, a[31:0]};
                cy = op_reg.doubleword_compare ? b : {{32{b[31]}}, b[31:0]};
            end
            ppc_alu_pkg::OP_CMPI:
            begin
                cmp = 1'b1;
                cx = op_reg.doubleword_compare ? a : {{32{a[31]}}, a[31:0]};
                cy = sx_imm;
            end
            ppc_alu_pkg::OP_CMPL:
            begin
                cmp = 1'b1; csgn = 1'b0;
                cx = op_reg.doubleword_compare ? a : {32'd0, a[31:0]};
                cy = op_reg.doubleword_compare ? b : {32'd0, b[31:0]};
            end
            ppc_alu_pkg::OP_CMPLI:
            begin
                cmp = 1'b1; csgn = 1'b0;
                cx = op_reg.doubleword_compare ? a : {32'd0, a[31:0]};
                cy = {48'd0, op_reg.imm};
            end
            ppc_alu_pkg::OP_CNTLZD: r = {57'd0, clz_n};
            ppc_alu_pkg::OP_CNTLZW:
            begin
                clz_v = {a[31:0], 32'd0};
                r = (a[31:0] == 32'd0) ? 64'd32 : {57'd0, clz_n};
            end
            ppc_alu_pkg::OP_DIVD, ppc_alu_pkg::OP_DIVDU: r = divres_reg;
            ppc_alu_pkg::OP_DIVW, ppc_alu_pkg::OP_DIVWU: r = {32'd0, divres_reg[31:0]};
            ppc_alu_pkg::OP_EQV:   r = ~(a ^ b);
            ppc_alu_pkg::OP_EXTSB: r = {{56{a[7]}}, a[7:0]};
            ppc_alu_pkg::OP_EXTSH: r = {{48{a[15]}}, a[15:0]};
            ppc_alu_pkg::OP_EXTSW: r = {{32{a[31]}}, a[31:0]};
            ppc_alu_pkg::OP_MULHD, ppc_alu_pkg::OP_MULHDU: r = mulhi_reg;
            ppc_alu_pkg::OP_MULHW, ppc_alu_pkg::OP_MULHWU: r = {32'd0, mullo_reg[63:32]};
            ppc_alu_pkg::OP_MULLD, ppc_alu_pkg::OP_MULLW: r = mullo_reg;
            ppc_alu_pkg::OP_MULLI:
            begin
                r = mullo_reg; rec = 1'b0;
            end
            ppc_alu_pkg::OP_NAND:  r = ~(a & b);
            ppc_alu_pkg::OP_NEG:   r = 64'd0 - a;
            ppc_alu_pkg::OP_NOR:   r = ~(a | b);
            ppc_alu_pkg::OP_OR:    r = a | b;
            ppc_alu_pkg::OP_ORC:   r = a | ~b;
            ppc_alu_pkg::OP_ORI:
            begin
                r = a | {48'd0, op_reg.imm}; rec = 1'b0;
            end
            ppc_alu_pkg::OP_ORIS:
            begin
                r = a | {32'd0, op_reg.imm, 16'd0}; rec = 1'b0;
            end
            ppc_alu_pkg::OP_RLDIC:
            begin
                msk = ppc_alu_pkg::mask_be(op_reg.mask_begin, 6'd63 - op_reg.shift);
                r = rot & msk;
            end
            ppc_alu_pkg::OP_RLDICL:
            begin
                msk = ppc_alu_pkg::mask_be(op_reg.mask_begin, 6'd63);
                r = rot & msk;
            end
            ppc_alu_pkg::OP_RLDICR:
            begin
                msk = ppc_alu_pkg::mask_be(6'd0, op_reg.mask_end);
                r = rot & msk;
            end
            ppc_alu_pkg::OP_RLDIMI:
            begin
                msk = ppc_alu_pkg::mask_be(op_reg.mask_begin, 6'd63 - op_reg.shift);
                r = (rot & msk) | (b & ~msk);
            end
            ppc_alu_pkg::OP_RLWIMI, ppc_alu_pkg::OP_RLWINM, ppc_alu_pkg::OP_RLWNM:
            begin
                // word copied into both halves, mask in the low word unless MB > ME, where it wraps
                rot_src = {a[31:0], a[31:0]};
                rot_n = (op_reg.func == ppc_alu_pkg::OP_RLWNM) ? {1'b0, b[4:0]}
                                                               : (op_reg.shift & 6'(ppc_alu_pkg::LOW5));
                msk = ppc_alu_pkg::mask_be({1'b1, op_reg.mask_begin[4:0]},
                                           {1'b1, op_reg.mask_end[4:0]});
                r = rot & msk;
                if (op_reg.func == ppc_alu_pkg::OP_RLWIMI)
                begin
                    r = r | (b & ~msk);
                end
            end
            ppc_alu_pkg::OP_SLW:
            begin
                n = b[5:0] & ppc_alu_pkg::LOW6;
                r = n[5] ? 64'd0 : {32'd0, a[31:0] << n[4:0]};
            end
            ppc_alu_pkg::OP_SRAW, ppc_alu_pkg::OP_SRAWI:
            begin
                n = (op_reg.func == ppc_alu_pkg::OP_SRAW) ? b[5:0] : {1'b0, op_reg.shift[4:0]};
                cset = 1'b1;
                if (n[5])
                begin
                    r = {64{w[63]}}; ca = w[63];
                end
                else
                begin
                    r = 64'($signed(w) >>> n);
                    ca = w[63] && ((w & ~({64{1'b1}} << n)) != 64'd0);
                end
            end
            ppc_alu_pkg::OP_SRW:
            begin
                n = b[5:0];
                r = n[5] ? 64'd0 : {32'd0, a[31:0] >> n[4:0]};
            end
            ppc_alu_pkg::OP_SUBF:  r = b - a;
            ppc_alu_pkg::OP_SUBFC:
            begin
                add_x = ~a; add_c = 1'b1; r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_SUBFE:
            begin
                add_x = ~a; add_c = carry_reg; r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_SUBFIC:
            begin
                add_x = ~a; add_y = sx_imm; add_c = 1'b1;
                r = sum[63:0]; ca = sum[64]; cset = 1'b1; rec = 1'b0;
            end
            ppc_alu_pkg::OP_SUBFME:
            begin
                add_x = ~a; add_y = '1; add_c = carry_reg;
                r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_SUBFZE:
            begin
                add_x = ~a; add_y = '0; add_c = carry_reg;
                r = sum[63:0]; ca = sum[64]; cset = 1'b1;
            end
            ppc_alu_pkg::OP_XOR:   r = a ^ b;
            ppc_alu_pkg::OP_XORI:
            begin
                r = a ^ {48'd0, op_reg.imm}; rec = 1'b0;
            end
            ppc_alu_pkg::OP_XORIS:
            begin
                r = a ^ {32'd0, op_reg.imm, 16'd0}; rec = 1'b0;
            end
            default:
            begin
                valid = 1'b0; rec = 1'b0;
            end
        endcase

        carry_next = cset ? ca : carry_reg;
        out_next   = '0;
        out_next.carry_out     = carry_next;
        out_next.carry_updated = cset;
        if (cmp)
        begin
            out_next.cr_updated = 1'b1;
            out_next.cr_index   = op_reg.cr_target;
            out_next.cr_value   = ppc_alu_pkg::cmp_code(cx, cy, csgn);
        end
        else if (valid)
        begin
            out_next.result       = r;
            out_next.result_valid = 1'b1;
            if (rec)
            begin
                out_next.cr_updated = 1'b1;
                out_next.cr_value   = ppc_alu_pkg::cmp_code(r, 64'd0, 1'b1);
            end
        end
    end

    assign out_data = out_reg;

endmodule

[rtl/core/ppc64_integer_alu.sv]
// Top level of the 64-bit PowerPC fixed-point unit.
// Depends on ppc_alu_pkg, ppc_alu_ctrl, ppc_alu_dp, ppc64_integer_alu_assert.svh.
//
//   channel | signals                         | payload
//   in      | in_valid / in_ready             | in_data  (ppc_alu_pkg::alu_in_t)
//   out     | out_valid / out_ready           | out_data (ppc_alu_pkg::alu_out_t)
//
// Simple ops: after input transfer the result is registered in FINISH and held in OUT.
// Multiplies: two multiply steps (MUL1, MUL2), then FINISH and OUT.
// Divides: setup, 64 radix-2 quotient-bit steps and a sign fix, then FINISH and OUT.
// One instruction in flight; in_ready is high only while idle, so a held result blocks input.
// Reset clears the controller and the carry flag; a result holds until taken.
`include "ppc64_integer_alu_assert.svh"

module ppc64_integer_alu (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ppc_alu_pkg::alu_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ppc_alu_pkg::alu_out_t out_data
);

    ppc_alu_pkg::ctl_cmd_t cmd;
    ppc_alu_pkg::ctl_sts_t sts;
    logic                  cmp_out;

    ppc_alu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ppc_alu_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .out_data (out_data),
        .cmd      (cmd),
        .sts      (sts)
    );

    // a CR field other than CR0 is only written by compares
    assign cmp_out = out_valid && out_data.cr_updated && (out_data.cr_index != 3'd0);

    `ALU_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "accepted while busy")
    `ALU_ASSERT_NXT(a_out_after_take, clk, rst_n, out_valid && out_ready, in_ready, "no idle")
    `ALU_ASSERT_IMP(a_cmp_no_write, clk, rst_n, cmp_out, !out_data.result_valid, "cmp write")

endmodule
